// ----- sv/lruc_pkg.sv -----
// ----------------------------------------------------------------------------
// lruc_pkg
// Shared constants, types and microcode encodings for the LRU store with
// timed eviction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lruc_pkg;

    // Store geometry (KEY_SPACE is a power of two, at most 2**KEY_FIELD_BITS)
    localparam int KEY_SPACE      = 16384;
    localparam int KEY_BITS       = $clog2(KEY_SPACE);
    localparam int KEY_FIELD_BITS = 14;
    localparam int VALUE_BITS     = 32;
    localparam int HELD_BITS      = $clog2(KEY_SPACE + 1);

    // Configuration register widths and reset values
    localparam int CAP_BITS    = 15;
    localparam int PERIOD_BITS = 16;
    localparam int CAP_RESET   = 16;

    // Stream and APB widths
    localparam int S_DATA_BITS   = ((KEY_FIELD_BITS + VALUE_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS   = ((VALUE_BITS + 7) / 8) * 8;
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    typedef logic [KEY_BITS-1:0]          key_t;
    typedef logic signed [VALUE_BITS-1:0] value_t;
    typedef logic [HELD_BITS-1:0]         held_t;
    typedef logic [CAP_BITS-1:0]          cap_t;
    typedef logic [PERIOD_BITS-1:0]       period_t;

    localparam key_t KEY_LAST = key_t'(KEY_SPACE - 1);

    // Access kinds
    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_PUT = 1'b1;

    // Register indexes
    localparam logic REG_CAP    = 1'b0;
    localparam logic REG_PERIOD = 1'b1;

    // Sequencer steps
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECIDE,
        ST_LINK,
        ST_CAPCHK,
        ST_EVCAP,
        ST_COUNT,
        ST_EVTMR
    } step_t;

    // Datapath operations
    typedef enum logic [2:0] {
        OP_NOP,
        OP_CLEAR,
        OP_ACCEPT,
        OP_DECIDE,
        OP_LINK,
        OP_EVICT,
        OP_COUNT
    } op_t;

    // Memory read address select
    typedef enum logic [1:0] {
        RD_NONE,
        RD_KEY,
        RD_LRU
    } rd_t;

    // Step hold condition
    typedef enum logic [1:0] {
        HOLD_NONE,
        HOLD_IN,
        HOLD_OUT
    } hold_t;

    // Branch condition: take the alternate step when true
    typedef enum logic [2:0] {
        BR_NONE,
        BR_CLR_MORE,
        BR_GET_MISS,
        BR_NO_CAP,
        BR_NO_FIRE
    } br_t;

    // One microcode word
    typedef struct packed {
        hold_t hold_on;
        op_t   op;
        rd_t   rd;
        br_t   br;
        step_t alt;
        step_t seq;
    } ucode_t;

    // Command from sequencer to datapath
    typedef struct packed {
        op_t op;
        rd_t rd;
    } cmd_t;

    // Status from datapath to sequencer
    typedef struct packed {
        logic clr_more;
        logic get_miss;
        logic cap_evict;
        logic fire;
    } stat_t;

endpackage

`default_nettype wire

// ----- sv/lruc_seq.sv -----
// ----------------------------------------------------------------------------
// lruc_seq
// Microcode sequencer: a read-only program of control words, a step
// register and conditional jumps on datapath status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lruc_seq (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    input  wire logic            out_free,
    input  lruc_pkg::stat_t      st,
    output lruc_pkg::cmd_t       cmd,
    output logic                 in_ready
);
    import lruc_pkg::*;

    // Control store
    function automatic ucode_t rom(input step_t s);
        ucode_t w;
        case (s)
            ST_CLEAR:  w = '{hold_on: HOLD_NONE, op: OP_CLEAR,  rd: RD_NONE,
                             br: BR_CLR_MORE, alt: ST_CLEAR,  seq: ST_IDLE};
            ST_IDLE:   w = '{hold_on: HOLD_IN,   op: OP_ACCEPT, rd: RD_KEY,
                             br: BR_NONE,     alt: ST_IDLE,   seq: ST_DECIDE};
            ST_DECIDE: w = '{hold_on: HOLD_OUT,  op: OP_DECIDE, rd: RD_NONE,
                             br: BR_GET_MISS, alt: ST_COUNT,  seq: ST_LINK};
            ST_LINK:   w = '{hold_on: HOLD_NONE, op: OP_LINK,   rd: RD_NONE,
                             br: BR_NONE,     alt: ST_LINK,   seq: ST_CAPCHK};
            ST_CAPCHK: w = '{hold_on: HOLD_NONE, op: OP_NOP,    rd: RD_LRU,
                             br: BR_NO_CAP,   alt: ST_COUNT,  seq: ST_EVCAP};
            ST_EVCAP:  w = '{hold_on: HOLD_NONE, op: OP_EVICT,  rd: RD_NONE,
                             br: BR_NONE,     alt: ST_EVCAP,  seq: ST_COUNT};
            ST_COUNT:  w = '{hold_on: HOLD_NONE, op: OP_COUNT,  rd: RD_LRU,
                             br: BR_NO_FIRE,  alt: ST_IDLE,   seq: ST_EVTMR};
            ST_EVTMR:  w = '{hold_on: HOLD_NONE, op: OP_EVICT,  rd: RD_NONE,
                             br: BR_NONE,     alt: ST_EVTMR,  seq: ST_IDLE};
            default:   w = '{hold_on: HOLD_NONE, op: OP_NOP,    rd: RD_NONE,
                             br: BR_NONE,     alt: ST_IDLE,   seq: ST_IDLE};
        endcase
        return w;
    endfunction

    step_t  step_reg;
    step_t  step_next;
    ucode_t word;
    logic   go;
    logic   take;

    // Step register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= ST_CLEAR;
        end else begin
            step_reg <= step_next;
        end
    end

    // Decode word, evaluate hold and branch, pick next step
    always_comb begin
        word = rom(step_reg);

        case (word.hold_on)
            HOLD_IN:  go = in_valid;
            HOLD_OUT: go = out_free;
            default:  go = 1'b1;
        endcase

        case (word.br)
            BR_CLR_MORE: take = st.clr_more;
            BR_GET_MISS: take = st.get_miss;
            BR_NO_CAP:   take = !st.cap_evict;
            BR_NO_FIRE:  take = !st.fire;
            default:     take = 1'b0;
        endcase

        step_next = step_reg;
        if (go) begin
            step_next = take ? word.alt : word.seq;
        end

        cmd.op   = go ? word.op : OP_NOP;
        cmd.rd   = go ? word.rd : RD_NONE;
        in_ready = (word.hold_on == HOLD_IN);
    end

endmodule

`default_nettype wire

// ----- sv/lruc_dp.sv -----
// ----------------------------------------------------------------------------
// lruc_dp
// Datapath: entry memories (valid, value, older and newer links), list head
// and tail, held count, access counter and the clearing pointer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lruc_dp (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  lruc_pkg::cmd_t        cmd,
    input  wire logic             in_kind,
    input  lruc_pkg::key_t        in_key,
    input  lruc_pkg::value_t      in_value,
    input  lruc_pkg::cap_t        cap_limit,
    input  lruc_pkg::period_t     period,
    output lruc_pkg::stat_t       st,
    output logic                  res_hit,
    output lruc_pkg::value_t      res_value
);
    import lruc_pkg::*;

    // Entry memories
    logic   valid_mem [KEY_SPACE];
    value_t value_mem [KEY_SPACE];
    key_t   older_mem [KEY_SPACE];
    key_t   newer_mem [KEY_SPACE];

    // Registered read data
    logic   valid_rd_reg;
    value_t value_rd_reg;
    key_t   older_rd_reg;
    key_t   newer_rd_reg;

    // Working registers
    key_t    tgt_reg,  tgt_next;
    logic    kind_reg, kind_next;
    value_t  val_reg,  val_next;
    key_t    mr_reg,   mr_next;
    key_t    lr_reg,   lr_next;
    held_t   held_reg, held_next;
    period_t cnt_reg,  cnt_next;
    key_t    clr_reg,  clr_next;

    // Write ports
    logic valid_we, valid_wd;
    key_t valid_wa;
    logic value_we;
    logic older_we;
    key_t older_wa, older_wd;
    logic newer_we;
    key_t newer_wa, newer_wd;

    logic    rd_en;
    key_t    rd_addr;
    logic    unl_en;
    period_t cnt_inc;

    assign rd_en   = (cmd.rd != RD_NONE);
    assign rd_addr = (cmd.rd == RD_KEY) ? in_key : lr_reg;
    assign cnt_inc = cnt_reg + period_t'(1);

    // Status for branches
    assign st.clr_more  = (clr_reg != KEY_LAST);
    assign st.get_miss  = (kind_reg == KIND_GET) && !valid_rd_reg;
    assign st.cap_evict = (kind_reg == KIND_PUT) && !valid_rd_reg && (held_reg > cap_limit);
    assign st.fire      = (period != '0) && (cnt_inc >= period);

    // Result of the access
    assign res_hit   = valid_rd_reg;
    assign res_value = ((kind_reg == KIND_GET) && valid_rd_reg) ? value_rd_reg : '0;

    // Memory reads
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            valid_rd_reg <= valid_mem[rd_addr];
            value_rd_reg <= value_mem[rd_addr];
            older_rd_reg <= older_mem[rd_addr];
            newer_rd_reg <= newer_mem[rd_addr];
        end
    end

    // Memory writes
    always_ff @(posedge aclk) begin
        if (valid_we) begin
            valid_mem[valid_wa] <= valid_wd;
        end
    end

    always_ff @(posedge aclk) begin
        if (value_we) begin
            value_mem[tgt_reg] <= val_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (older_we) begin
            older_mem[older_wa] <= older_wd;
        end
    end

    always_ff @(posedge aclk) begin
        if (newer_we) begin
            newer_mem[newer_wa] <= newer_wd;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mr_reg   <= '0;
            lr_reg   <= '0;
            held_reg <= '0;
            cnt_reg  <= '0;
            clr_reg  <= '0;
        end else begin
            mr_reg   <= mr_next;
            lr_reg   <= lr_next;
            held_reg <= held_next;
            cnt_reg  <= cnt_next;
            clr_reg  <= clr_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        tgt_reg  <= tgt_next;
        kind_reg <= kind_next;
        val_reg  <= val_next;
    end

    // Execute the current command
    always_comb begin
        tgt_next  = tgt_reg;
        kind_next = kind_reg;
        val_next  = val_reg;
        mr_next   = mr_reg;
        lr_next   = lr_reg;
        held_next = held_reg;
        cnt_next  = cnt_reg;
        clr_next  = clr_reg;
        valid_we  = 1'b0;
        valid_wa  = tgt_reg;
        valid_wd  = 1'b0;
        value_we  = 1'b0;
        older_we  = 1'b0;
        older_wa  = '0;
        older_wd  = '0;
        newer_we  = 1'b0;
        newer_wa  = '0;
        newer_wd  = '0;
        unl_en    = 1'b0;

        // Capture the entry that the read targets
        case (cmd.rd)
            RD_KEY:  tgt_next = in_key;
            RD_LRU:  tgt_next = lr_reg;
            default: tgt_next = tgt_reg;
        endcase

        case (cmd.op)
            OP_CLEAR: begin
                valid_we = 1'b1;
                valid_wa = clr_reg;
                clr_next = clr_reg + key_t'(1);
            end
            OP_ACCEPT: begin
                kind_next = in_kind;
                val_next  = in_value;
            end
            OP_DECIDE: begin
                unl_en = valid_rd_reg;
            end
            OP_LINK: begin
                // Put the target at the most recent end
                if (held_reg == '0) begin
                    mr_next = tgt_reg;
                    lr_next = tgt_reg;
                end else begin
                    older_we = 1'b1;
                    older_wa = tgt_reg;
                    older_wd = mr_reg;
                    newer_we = 1'b1;
                    newer_wa = mr_reg;
                    newer_wd = tgt_reg;
                    mr_next  = tgt_reg;
                end
                held_next = held_reg + held_t'(1);
                if (kind_reg == KIND_PUT) begin
                    valid_we = 1'b1;
                    valid_wd = 1'b1;
                    value_we = 1'b1;
                end
            end
            OP_EVICT: begin
                if (held_reg != '0) begin
                    valid_we = 1'b1;
                    unl_en   = 1'b1;
                end
            end
            OP_COUNT: begin
                cnt_next = st.fire ? '0 : cnt_inc;
            end
            default: begin
            end
        endcase

        // Remove the target from the list
        if (unl_en) begin
            if (held_reg <= held_t'(1)) begin
                held_next = '0;
                mr_next   = '0;
                lr_next   = '0;
            end else begin
                if (tgt_reg == mr_reg) begin
                    mr_next = older_rd_reg;
                end else begin
                    older_we = 1'b1;
                    older_wa = newer_rd_reg;
                    older_wd = older_rd_reg;
                end
                if (tgt_reg == lr_reg) begin
                    lr_next = newer_rd_reg;
                end else begin
                    newer_we = 1'b1;
                    newer_wa = older_rd_reg;
                    newer_wd = newer_rd_reg;
                end
                held_next = held_reg - held_t'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_link_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_LINK && held_reg == '0)
        |=> (mr_reg == lr_reg && held_reg == held_t'(1)))
        else $error("first link did not set head and tail to one entry");

    a_timer_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_COUNT && st.fire) |=> (cnt_reg == '0))
        else $error("access counter did not restart on timed eviction");

    a_evict_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_EVICT && held_reg == held_t'(1))
        |=> (held_reg == '0 && mr_reg == '0 && lr_reg == '0))
        else $error("evicting the last entry did not empty the store");

    a_hit_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_DECIDE && valid_rd_reg) |-> (held_reg != '0))
        else $error("hit on a store that holds no entries");
`endif

endmodule

`default_nettype wire

// ----- sv/lru_cache_with_periodic_eviction.sv -----
// ----------------------------------------------------------------------------
// lru_cache_with_periodic_eviction
// Directly indexed key-value store kept in least-recently-used order. Each
// input beat is a get (tuser 0) or a put (tuser 1) of a key and returns one
// result beat: hit in tuser and, on a get hit, the stored value in tdata.
// A put of a new key that takes the held count above capacity_limit evicts
// the least recent entry; every access advances a counter, and when it
// reaches overheat_period (0 disables) the least recent entry is evicted.
// An access runs the microcode steps accept and decide, then link and capacity
// check unless it is a get miss, then count, plus an evict step for each
// eviction, reading and rewriting the single-write-port link memories one
// step at a time; the decide step also waits while the previous result beat
// is not yet taken. After reset a clearing pass resets the valid memory,
// during which no input beat is accepted; configuration writes are taken at
// any time. Registers: capacity_limit at byte address 0, overheat_period at 4.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lru_cache_with_periodic_eviction (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // input stream
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // s_tdata fields from bit 0: key, value, zero pad
    input  wire logic [lruc_pkg::S_DATA_BITS-1:0]     s_tdata,
    // s_tuser fields from bit 0: kind
    input  wire logic [0:0]                           s_tuser,
    // result stream
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // m_tdata fields from bit 0: read_value
    output logic [lruc_pkg::M_DATA_BITS-1:0]          m_tdata,
    // m_tuser fields from bit 0: hit
    output logic [0:0]                                m_tuser,
    // configuration port
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [lruc_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  wire logic [lruc_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [lruc_pkg::APB_DATA_BITS-1:0]        prdata,
    output logic                                      pready
);
    import lruc_pkg::*;

    cap_t    cap_reg,    cap_next;
    period_t period_reg, period_next;
    logic    m_valid_reg, m_valid_next;
    logic    m_hit_reg,   m_hit_next;
    value_t  m_value_reg, m_value_next;

    cmd_t    cmd;
    stat_t   st;
    logic    in_ready;
    logic    out_free;
    logic    res_hit;
    value_t  res_value;
    logic    cfg_wr;
    logic    reg_sel;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign reg_sel  = paddr[APB_ADDR_BITS-1];
    assign s_tready = in_ready;
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_hit_reg;
    assign m_tdata  = M_DATA_BITS'($unsigned(m_value_reg));

    // Register file writes
    always_comb begin
        cap_next    = cap_reg;
        period_next = period_reg;
        if (cfg_wr) begin
            case (reg_sel)
                REG_CAP:    cap_next    = pwdata[CAP_BITS-1:0];
                REG_PERIOD: period_next = pwdata[PERIOD_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register file reads
    always_comb begin
        case (reg_sel)
            REG_CAP:    prdata = APB_DATA_BITS'(cap_reg);
            REG_PERIOD: prdata = APB_DATA_BITS'(period_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg    <= cap_t'(CAP_RESET);
            period_reg <= '0;
        end else begin
            cap_reg    <= cap_next;
            period_reg <= period_next;
        end
    end

    // Result register: load on decide, drop when the beat is taken
    always_comb begin
        m_valid_next = m_valid_reg;
        m_hit_next   = m_hit_reg;
        m_value_next = m_value_reg;
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.op == OP_DECIDE) begin
            m_valid_next = 1'b1;
            m_hit_next   = res_hit;
            m_value_next = res_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_hit_reg   <= m_hit_next;
        m_value_reg <= m_value_next;
    end

    lruc_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .out_free (out_free),
        .st       (st),
        .cmd      (cmd),
        .in_ready (in_ready)
    );

    lruc_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .in_kind   (s_tuser[0]),
        .in_key    (s_tdata[KEY_BITS-1:0]),
        .in_value  (s_tdata[KEY_FIELD_BITS +: VALUE_BITS]),
        .cap_limit (cap_reg),
        .period    (period_reg),
        .st        (st),
        .res_hit   (res_hit),
        .res_value (res_value)
    );

endmodule

`default_nettype wire
